// ===== hw/rtl/scoped_symbol_table_defines.svh =====
// ----------------------------------------------------------------------------
// scoped_symbol_table_defines.svh
// Assertion macros used by the symbol table checker.
// ----------------------------------------------------------------------------
`ifndef SCOPED_SYMBOL_TABLE_DEFINES_SVH
`define SCOPED_SYMBOL_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SSYM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ssym: implication failed");

// Next-cycle implication, disabled while reset is high.
`define SSYM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ssym: next-cycle implication failed");

`endif

// ===== hw/rtl/ssym_pkg.sv =====
// ----------------------------------------------------------------------------
// ssym_pkg
// Types, codes and sizes of the scoped symbol table.
// ----------------------------------------------------------------------------
package ssym_pkg;

   localparam int CAPACITY   = 64;
   localparam int MAX_DEPTH  = 255;
   localparam int KEY_BITS   = 64;
   localparam int VALUE_BITS = 64;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int LVL_W = $clog2(MAX_DEPTH + 1);

   // command codes
   localparam logic [2:0] CMD_CLEAR = 3'd0;
   localparam logic [2:0] CMD_ENTER = 3'd1;
   localparam logic [2:0] CMD_LEAVE = 3'd2;
   localparam logic [2:0] CMD_SET   = 3'd3;
   localparam logic [2:0] CMD_GET   = 3'd4;

   // status codes
   localparam logic [1:0] STS_OK        = 2'd0;
   localparam logic [1:0] STS_FULL      = 2'd1;
   localparam logic [1:0] STS_NOT_FOUND = 2'd2;
   localparam logic [1:0] STS_DEPTH     = 2'd3;

   typedef struct packed {
      logic [2:0]  command;
      logic [63:0] key_word;
      logic [63:0] value_word;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] found_value;
      logic [7:0]  depth_now;
      logic [6:0]  entries_now;
   } rsp_type;

   // one stored entry
   typedef struct packed {
      logic [KEY_BITS-1:0]   key;
      logic [VALUE_BITS-1:0] value;
      logic [LVL_W-1:0]      level;
   } row_type;

   // compare results for one entry against the current command
   typedef struct packed {
      logic key_eq;
      logic lvl_eq;
      logic lvl_lt;
      logic lvl_le;
      logic lvl_ge_best;
   } match_type;

endpackage

// ===== hw/rtl/ssym_ram.sv =====
// ----------------------------------------------------------------------------
// ssym_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssym_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ssym_match.sv =====
// ----------------------------------------------------------------------------
// ssym_match
// Compare unit: checks one stored entry against the command key and levels.
// ----------------------------------------------------------------------------
module ssym_match import ssym_pkg::*; (
   input  row_type               row,
   input  logic [KEY_BITS-1:0]   key,
   input  logic [LVL_W-1:0]      depth,
   input  logic [LVL_W-1:0]      best_level,
   output match_type             result
);

   always_comb begin
      result.key_eq      = (row.key == key);
      result.lvl_eq      = (row.level == depth);
      result.lvl_lt      = (row.level < depth);
      result.lvl_le      = (row.level <= depth);
      result.lvl_ge_best = (row.level >= best_level);
   end

endmodule

// ===== hw/rtl/scoped_symbol_table.sv =====
// ----------------------------------------------------------------------------
// scoped_symbol_table
// Fixed-capacity variable table with nested scopes.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low; every command
// returns exactly one response word, shown on rsp_data for a single cycle
// with rsp_strobe high, and the receiver has no way to hold it off. Clear,
// enter scope and unknown commands (and leave at depth zero) finish at once:
// the response appears the cycle after the command is taken and busy never
// rises, so a new command may follow in the next cycle. Leave, set and get
// walk the stored entries through one RAM read port and one compare unit,
// one entry per cycle, then respond from a done state; busy stays high
// through the walk and the done state and falls as the response appears. Set
// stops at the first entry it updates. Leave compacts the table in place during
// the same walk, writing each kept entry back below the read pointer. Stored
// entries need no clearing: only entries below the entry count are ever read.
// ----------------------------------------------------------------------------
module scoped_symbol_table import ssym_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [2:0]            cmd_ff, cmd_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [LVL_W-1:0]      depth_ff, depth_in;
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  pipe_vld_ff, pipe_vld_in;
   logic [IDX_W-1:0]      pipe_idx_ff, pipe_idx_in;
   logic [CNT_W-1:0]      wr_idx_ff, wr_idx_in;
   logic                  hit_ff, hit_in;
   logic [LVL_W-1:0]      best_ff, best_in;
   logic [VALUE_BITS-1:0] found_ff, found_in;
   logic                  rsp_strobe_ff, rsp_strobe_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  accept;
   logic                  issue;
   logic                  set_hit_now;
   logic                  ram_wr_en;
   logic [IDX_W-1:0]      ram_wr_addr;
   row_type               ram_wr_data;
   logic                  ram_rd_en;
   row_type               rd_row;
   match_type             mt;

   // Build a response word from internal counts.
   function automatic rsp_type make_rsp(input logic [1:0]            sts,
                                        input logic [VALUE_BITS-1:0] fv,
                                        input logic [LVL_W-1:0]      dep,
                                        input logic [CNT_W-1:0]      cnt);
      rsp_type r;
      r.status      = sts;
      r.found_value = 64'(fv);
      r.depth_now   = 8'(dep);
      r.entries_now = 7'(cnt);
      return r;
   endfunction

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Entry store: key, value and level of each entry in one row.
   ssym_ram #(
      .WIDTH ($bits(row_type)),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (rd_idx_ff[IDX_W-1:0]),
      .rd_data (rd_row)
   );

   // Shared compare unit, applied to the entry read in the previous cycle.
   ssym_match u_match (
      .row        (rd_row),
      .key        (key_ff),
      .depth      (depth_ff),
      .best_level (best_ff),
      .result     (mt)
   );

   // First matching entry of a set at the current level.
   assign set_hit_now = pipe_vld_ff && (cmd_ff == CMD_SET) && !hit_ff &&
                        mt.key_eq && mt.lvl_eq;

   // Read the next entry unless the walk is over or a set has found its entry.
   assign issue = (state_ff == S_SCAN) && (rd_idx_ff < count_ff) &&
                  !((cmd_ff == CMD_SET) && (hit_ff || set_hit_now));

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      count_in      = count_ff;
      depth_in      = depth_ff;
      rd_idx_in     = rd_idx_ff;
      pipe_vld_in   = 1'b0;
      pipe_idx_in   = pipe_idx_ff;
      wr_idx_in     = wr_idx_ff;
      hit_in        = hit_ff;
      best_in       = best_ff;
      found_in      = found_ff;
      rsp_strobe_in = 1'b0;
      rsp_data_in   = rsp_data_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = pipe_idx_ff;
      ram_wr_data   = rd_row;
      ram_rd_en     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd_in    = req_data.command;
               key_in    = KEY_BITS'(req_data.key_word);
               val_in    = VALUE_BITS'(req_data.value_word);
               rd_idx_in = '0;
               wr_idx_in = '0;
               hit_in    = 1'b0;
               best_in   = '0;
               found_in  = '0;
               unique case (req_data.command)
                  CMD_CLEAR: begin
                     count_in      = '0;
                     depth_in      = '0;
                     rsp_strobe_in = 1'b1;
                     rsp_data_in   = make_rsp(STS_OK, '0, '0, '0);
                  end
                  CMD_ENTER: begin
                     rsp_strobe_in = 1'b1;
                     if (depth_ff >= LVL_W'(MAX_DEPTH)) begin
                        rsp_data_in = make_rsp(STS_DEPTH, '0, depth_ff, count_ff);
                     end else begin
                        depth_in    = depth_ff + LVL_W'(1);
                        rsp_data_in = make_rsp(STS_OK, '0, depth_ff + LVL_W'(1),
                                               count_ff);
                     end
                  end
                  CMD_LEAVE: begin
                     if (depth_ff == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_data_in   = make_rsp(STS_OK, '0, depth_ff, count_ff);
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  CMD_SET, CMD_GET: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     // unknown command: no change
                     rsp_strobe_in = 1'b1;
                     rsp_data_in   = make_rsp(STS_OK, '0, depth_ff, count_ff);
                  end
               endcase
            end
         end

         S_SCAN: begin
            // advance the read pointer; read data lands next cycle
            if (issue) begin
               ram_rd_en   = 1'b1;
               rd_idx_in   = rd_idx_ff + CNT_W'(1);
               pipe_vld_in = 1'b1;
               pipe_idx_in = rd_idx_ff[IDX_W-1:0];
            end else begin
               state_in = S_DONE;
            end

            if (pipe_vld_ff) begin
               unique case (cmd_ff)
                  CMD_GET: begin
                     // deepest level wins, later index wins on a tie
                     if (mt.key_eq && mt.lvl_le && (!hit_ff || mt.lvl_ge_best)) begin
                        hit_in   = 1'b1;
                        best_in  = rd_row.level;
                        found_in = rd_row.value;
                     end
                  end
                  CMD_SET: begin
                     if (set_hit_now) begin
                        hit_in            = 1'b1;
                        ram_wr_en         = 1'b1;
                        ram_wr_addr       = pipe_idx_ff;
                        ram_wr_data.key   = rd_row.key;
                        ram_wr_data.value = val_ff;
                        ram_wr_data.level = rd_row.level;
                     end
                  end
                  CMD_LEAVE: begin
                     // keep outer entries, compact them toward index zero
                     if (mt.lvl_lt) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = wr_idx_ff[IDX_W-1:0];
                        ram_wr_data = rd_row;
                        wr_idx_in   = wr_idx_ff + CNT_W'(1);
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_DONE: begin
            state_in      = S_IDLE;
            rsp_strobe_in = 1'b1;
            unique case (cmd_ff)
               CMD_LEAVE: begin
                  count_in    = wr_idx_ff;
                  depth_in    = depth_ff - LVL_W'(1);
                  rsp_data_in = make_rsp(STS_OK, '0, depth_ff - LVL_W'(1), wr_idx_ff);
               end
               CMD_SET: begin
                  if (hit_ff) begin
                     rsp_data_in = make_rsp(STS_OK, '0, depth_ff, count_ff);
                  end else if (count_ff >= CNT_W'(CAPACITY)) begin
                     rsp_data_in = make_rsp(STS_FULL, '0, depth_ff, count_ff);
                  end else begin
                     // append a new entry at the end
                     ram_wr_en         = 1'b1;
                     ram_wr_addr       = count_ff[IDX_W-1:0];
                     ram_wr_data.key   = key_ff;
                     ram_wr_data.value = val_ff;
                     ram_wr_data.level = depth_ff;
                     count_in          = count_ff + CNT_W'(1);
                     rsp_data_in       = make_rsp(STS_OK, '0, depth_ff,
                                                  count_ff + CNT_W'(1));
                  end
               end
               CMD_GET: begin
                  if (hit_ff) begin
                     rsp_data_in = make_rsp(STS_OK, found_ff, depth_ff, count_ff);
                  end else begin
                     rsp_data_in = make_rsp(STS_NOT_FOUND, '0, depth_ff, count_ff);
                  end
               end
               default: begin
                  rsp_data_in = make_rsp(STS_OK, '0, depth_ff, count_ff);
               end
            endcase
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         depth_ff      <= '0;
         pipe_vld_ff   <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         depth_ff      <= depth_in;
         pipe_vld_ff   <= pipe_vld_in;
         hit_ff        <= hit_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload and walk registers
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      key_ff      <= key_in;
      val_ff      <= val_in;
      rd_idx_ff   <= rd_idx_in;
      pipe_idx_ff <= pipe_idx_in;
      wr_idx_ff   <= wr_idx_in;
      best_ff     <= best_in;
      found_ff    <= found_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ===== hw/rtl/ssym_checker.sv =====
// ----------------------------------------------------------------------------
// ssym_checker
// Port-level checks of the scoped symbol table, bound to the top level.
// ----------------------------------------------------------------------------
`include "scoped_symbol_table_defines.svh"

module ssym_checker import ssym_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   logic limit_rsp;

   assign limit_rsp = rsp_strobe && (rsp_data.status == STS_DEPTH);

   // a taken command either answers next cycle or holds busy
   `SSYM_ASSERT_NXT(a_accept_progress, clock, reset, start && !busy, rsp_strobe || busy)

   // the end of a walk always delivers its response
   `SSYM_ASSERT_IMP(a_walk_ends_with_rsp, clock, reset, $fell(busy), rsp_strobe)

   // every response follows a taken command or the end of a walk
   `SSYM_ASSERT_IMP(a_rsp_has_cause, clock, reset, rsp_strobe, $past(start && !busy) || $past(busy))

   // depth limit reported only at the maximum depth
   `SSYM_ASSERT_IMP(a_depth_limit, clock, reset, limit_rsp, rsp_data.depth_now == 8'(MAX_DEPTH))

endmodule

bind scoped_symbol_table ssym_checker u_ssym_checker (.*);
